/* rtl/kds_pkg.sv */
package kds_pkg;

  localparam int unsigned MaxKeys = 32;
  localparam int unsigned NumKeys = 16;
  localparam int unsigned SlotW   = $clog2(NumKeys);
  localparam int unsigned CntW    = $clog2(MaxKeys + 1);

  localparam logic [7:0] NoKey = 8'hFF;

  localparam logic [1:0] ActScan    = 2'd0;
  localparam logic [1:0] ActRemap   = 2'd1;
  localparam logic [1:0] ActRestart = 2'd2;

  localparam logic [2:0] ModeRelease = 3'd0;
  localparam logic [2:0] ModeDbDown  = 3'd1;
  localparam logic [2:0] ModePressed = 3'd2;
  localparam logic [2:0] ModeDbUp    = 3'd3;
  localparam logic [2:0] ModeDone    = 3'd4;

  localparam logic [7:0] KeyCodes [NumKeys] = '{
    8'hEE, 8'hDE, 8'hBE, 8'h7E,
    8'hED, 8'hDD, 8'hBD, 8'h7D,
    8'hEB, 8'hDB, 8'hBB, 8'h7B,
    8'hE7, 8'hD7, 8'hB7, 8'h77
  };

  localparam logic [7:0] DefaultSymbols [NumKeys] = '{
    "1", "2", "3", "A", "4", "5", "6", "B",
    "7", "8", "9", "C", "*", "0", "#", "D"
  };

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] keycode;
    logic [7:0] old_symbol;
    logic [7:0] new_symbol;
  } in_t;

  typedef struct packed {
    logic       appended;
    logic [7:0] symbol;
    logic [4:0] position;
    logic [5:0] length;
    logic       terminated;
    logic       ready_res;
    logic [2:0] mode_now;
    logic       overflow;
  } out_t;

endpackage

/* rtl/kds_keymap.sv */
module kds_keymap import kds_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] keycode_i,
  input  logic       remap_i,
  input  logic [7:0] old_symbol_i,
  input  logic [7:0] new_symbol_i,
  output logic       hit_o,
  output logic [7:0] symbol_o
);

  logic [7:0]       table_q [NumKeys];
  logic [SlotW-1:0] slot;
  logic [SlotW-1:0] rslot;
  logic             rhit;

  always_comb begin
    hit_o = 1'b0;
    slot  = '0;
    for (int i = 0; i < NumKeys; i++) begin
      if (keycode_i == KeyCodes[i]) begin
        hit_o = 1'b1;
        slot  = SlotW'(i);
      end
    end
    symbol_o = table_q[slot];
  end

  // lowest slot holding the old symbol wins
  always_comb begin
    rhit  = 1'b0;
    rslot = '0;
    for (int i = NumKeys - 1; i >= 0; i--) begin
      if (table_q[i] == old_symbol_i) begin
        rhit  = 1'b1;
        rslot = SlotW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumKeys; i++) table_q[i] <= DefaultSymbols[i];
    end else if (remap_i && rhit) begin
      table_q[rslot] <= new_symbol_i;
    end
  end

endmodule

/* rtl/keypad_debounce_string_entry.sv */
// An accepted beat's result beat is registered for the next cycle.
// Throughput: one beat per cycle while the output is not stalled; a new
// beat is taken while the result register drains in the same cycle.
// Reset: release mode, count and flags cleared, candidate code 0, symbol
// table loaded with its default symbols; no clearing pass.
module keypad_debounce_string_entry import kds_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  logic [2:0]      mode_q, mode_d;
  logic [7:0]      cand_q, cand_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            term_q, term_d;
  logic            rdy_q, rdy_d;
  logic            out_valid_q;
  out_t            out_q, res;
  logic            accept;
  logic            hit;
  logic [7:0]      sym;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  kds_keymap u_keymap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .keycode_i   (in_i.keycode),
    .remap_i     (accept && (in_i.action == ActRemap)),
    .old_symbol_i(in_i.old_symbol),
    .new_symbol_i(in_i.new_symbol),
    .hit_o       (hit),
    .symbol_o    (sym)
  );

  always_comb begin
    mode_d       = mode_q;
    cand_d       = cand_q;
    cnt_d        = cnt_q;
    term_d       = term_q;
    rdy_d        = rdy_q;
    res          = '0;
    case (in_i.action)
      ActRestart: begin
        cnt_d  = '0;
        term_d = 1'b0;
        rdy_d  = 1'b0;
        mode_d = ModeRelease;
      end
      ActScan: begin
        case (mode_q)
          ModeRelease: begin
            if (in_i.keycode != NoKey) begin
              cand_d = in_i.keycode;
              mode_d = ModeDbDown;
            end
          end
          ModeDbDown: begin
            if (in_i.keycode == cand_q) begin
              if (hit) begin
                if (sym == 8'd0) begin
                  res.position = 5'(cnt_q);
                  term_d       = 1'b1;
                end else if (cnt_q >= CntW'(MaxKeys)) begin
                  res.overflow = 1'b1;
                end else begin
                  res.position = 5'(cnt_q);
                  res.appended = 1'b1;
                  res.symbol   = sym;
                  cnt_d        = cnt_q + 1'b1;
                end
              end
              mode_d = ModePressed;
            end else begin
              mode_d = ModeRelease;
            end
          end
          ModePressed: begin
            if (in_i.keycode != cand_q) mode_d = ModeDbUp;
          end
          ModeDbUp: begin
            if (in_i.keycode == cand_q) begin
              mode_d = ModePressed;
            end else if (term_q) begin
              rdy_d  = 1'b1;
              mode_d = ModeDone;
            end else begin
              mode_d = ModeRelease;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    res.length     = 6'(cnt_d);
    res.terminated = term_d;
    res.ready_res  = rdy_d;
    res.mode_now   = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeRelease;
      cand_q      <= '0;
      cnt_q       <= '0;
      term_q      <= 1'b0;
      rdy_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        mode_q <= mode_d;
        cand_q <= cand_d;
        cnt_q  <= cnt_d;
        term_q <= term_d;
        rdy_q  <= rdy_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_q <= res;
  end

endmodule
